### rtl/core/ipv4_lpm_pkg.sv
// shared types, codes and helpers for the ipv4 longest prefix match core
// no dependencies; used by ipv4_lpm_table and ipv4_longest_prefix_match_core
package ipv4_lpm_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;

  localparam logic [1:0]  OP_CLEAR  = 2'd0;
  localparam logic [1:0]  OP_INSERT = 2'd1;
  localparam logic [1:0]  OP_LOOKUP = 2'd2;

  localparam logic [15:0] NO_PORT   = 16'hFFFF;
  localparam logic [5:0]  MAX_LEN   = 6'd32;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] address;
    logic [5:0]  prefix_length;
    logic [15:0] route_port;
  } req_t;

  typedef struct packed {
    logic [15:0] out_port;
    logic        hit;
    logic        full_drop;
  } rsp_t;

  typedef struct packed {
    logic [31:0] prefix;
    logic [5:0]  length;
    logic [15:0] port;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_DONE
  } state_t;

  function automatic logic [5:0] sat_len(input logic [5:0] len);
    return (len > MAX_LEN) ? MAX_LEN : len;
  endfunction

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    logic [5:0] l;
    l = sat_len(len);
    if (l == 6'd0) begin
      return 32'h0;
    end
    return 32'hFFFF_FFFF << (MAX_LEN - l);
  endfunction

endpackage

### rtl/core/ipv4_lpm_table.sv
// route table storage: one write port, one read port with registered data
// depends on ipv4_lpm_pkg for the entry type
module ipv4_lpm_table #(
  parameter int ENTRIES = ipv4_lpm_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] wr_addr,
  input  ipv4_lpm_pkg::entry_t                        wr_data,
  input  logic                                        rd_en,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
  output ipv4_lpm_pkg::entry_t                        rd_data
);

  ipv4_lpm_pkg::entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/ipv4_longest_prefix_match_core.sv
// ipv4 longest prefix match routing table: sequencer and shared compare unit
// depends on ipv4_lpm_pkg and ipv4_lpm_table
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------
//  req     | in        | req_valid, req_stall | req (clear/insert/lookup)
//  rsp     | out       | rsp_valid, rsp_stall | rsp (port, hit, full_drop)
//
//  clear and unused codes: result loaded in the done step once rsp is free
//  insert and lookup: one table read per cycle through the single ram port;
//  an insert that finds its prefix stops early
//  req_stall is high from transfer until the result is loaded for rsp
//  a waiting result does not block the next request transfer
//  reset empties the table (route count to zero); entries need no clearing
module ipv4_longest_prefix_match_core #(
  parameter int TABLE_ENTRIES = ipv4_lpm_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  ipv4_lpm_pkg::req_t  req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output ipv4_lpm_pkg::rsp_t  rsp
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

  ipv4_lpm_pkg::state_t state, state_next;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic          rd_pend, rd_pend_next;
  logic [AW-1:0] rd_idx, rd_idx_next;
  logic          found, found_next;
  logic [AW-1:0] found_idx, found_idx_next;
  logic [15:0]   found_port, found_port_next;
  logic          best_hit, best_hit_next;
  logic [5:0]    best_len, best_len_next;
  logic [15:0]   best_port, best_port_next;
  logic          drop, drop_next;
  logic [1:0]    op_q, op_q_next;
  logic [31:0]   addr_q, addr_q_next;
  logic [5:0]    len_q, len_q_next;
  logic [15:0]   port_q, port_q_next;
  logic          rsp_valid_next;
  ipv4_lpm_pkg::rsp_t rsp_next;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  ipv4_lpm_pkg::entry_t wr_data;
  logic                 rd_en;
  ipv4_lpm_pkg::entry_t rd_data;

  logic match_now;
  logic better;
  logic can_issue;
  logic [5:0] req_len;

  ipv4_lpm_table #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx[AW-1:0]),
    .rd_data (rd_data)
  );

  // shared compare unit
  always_comb begin
    if (op_q == ipv4_lpm_pkg::OP_INSERT) begin
      match_now = rd_pend && (rd_data.prefix == addr_q) && (rd_data.length == len_q);
    end else begin
      match_now = rd_pend &&
                  (((addr_q ^ rd_data.prefix) & ipv4_lpm_pkg::prefix_mask(rd_data.length))
                   == 32'h0);
    end
    better = !best_hit || (rd_data.length > best_len) ||
             ((rd_data.length == best_len) && (rd_data.port < best_port));
  end

  assign can_issue = (idx < count);
  assign req_len   = ipv4_lpm_pkg::sat_len(req.prefix_length);
  assign req_stall = (state != ipv4_lpm_pkg::ST_IDLE);

  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    rd_pend_next    = rd_pend;
    rd_idx_next     = rd_idx;
    found_next      = found;
    found_idx_next  = found_idx;
    found_port_next = found_port;
    best_hit_next   = best_hit;
    best_len_next   = best_len;
    best_port_next  = best_port;
    drop_next       = drop;
    op_q_next       = op_q;
    addr_q_next     = addr_q;
    len_q_next      = len_q;
    port_q_next     = port_q;
    rsp_next        = rsp;
    rsp_valid_next  = rsp_valid && rsp_stall;
    wr_en           = 1'b0;
    wr_addr         = count[AW-1:0];
    wr_data         = '{prefix: addr_q, length: len_q, port: port_q};
    rd_en           = 1'b0;

    unique case (state)
      ipv4_lpm_pkg::ST_IDLE: begin
        if (req_valid) begin
          op_q_next      = req.operation;
          len_q_next     = req_len;
          port_q_next    = req.route_port;
          addr_q_next    = (req.operation == ipv4_lpm_pkg::OP_INSERT) ?
                           (req.address & ipv4_lpm_pkg::prefix_mask(req_len)) : req.address;
          idx_next       = '0;
          rd_pend_next   = 1'b0;
          found_next     = 1'b0;
          best_hit_next  = 1'b0;
          best_len_next  = 6'd0;
          best_port_next = ipv4_lpm_pkg::NO_PORT;
          drop_next      = 1'b0;
          if (req.operation == ipv4_lpm_pkg::OP_CLEAR) begin
            count_next = '0;
          end
          if ((req.operation == ipv4_lpm_pkg::OP_INSERT) ||
              (req.operation == ipv4_lpm_pkg::OP_LOOKUP)) begin
            state_next = ipv4_lpm_pkg::ST_SCAN;
          end else begin
            state_next = ipv4_lpm_pkg::ST_DONE;
          end
        end
      end
      ipv4_lpm_pkg::ST_SCAN: begin
        rd_pend_next = 1'b0;
        if (match_now && (op_q == ipv4_lpm_pkg::OP_INSERT)) begin
          found_next      = 1'b1;
          found_idx_next  = rd_idx;
          found_port_next = rd_data.port;
          state_next      = ipv4_lpm_pkg::ST_FINISH;
        end else begin
          if (match_now && better) begin
            best_hit_next  = 1'b1;
            best_len_next  = rd_data.length;
            best_port_next = rd_data.port;
          end
          if (can_issue) begin
            rd_en        = 1'b1;
            idx_next     = idx + CW'(1);
            rd_pend_next = 1'b1;
            rd_idx_next  = idx[AW-1:0];
          end else if (!rd_pend) begin
            state_next = ipv4_lpm_pkg::ST_FINISH;
          end
        end
      end
      ipv4_lpm_pkg::ST_FINISH: begin
        if (op_q == ipv4_lpm_pkg::OP_INSERT) begin
          if (found) begin
            wr_en        = 1'b1;
            wr_addr      = found_idx;
            wr_data.port = (port_q < found_port) ? port_q : found_port;
          end else if (count < FULL_COUNT) begin
            wr_en      = 1'b1;
            count_next = count + CW'(1);
          end else begin
            drop_next = 1'b1;
          end
        end
        state_next = ipv4_lpm_pkg::ST_DONE;
      end
      ipv4_lpm_pkg::ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_next       = '{out_port: best_port, hit: best_hit, full_drop: drop};
          rsp_valid_next = 1'b1;
          state_next     = ipv4_lpm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ipv4_lpm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ipv4_lpm_pkg::ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    rd_pend    <= rd_pend_next;
    rd_idx     <= rd_idx_next;
    found      <= found_next;
    found_idx  <= found_idx_next;
    found_port <= found_port_next;
    best_hit   <= best_hit_next;
    best_len   <= best_len_next;
    best_port  <= best_port_next;
    drop       <= drop_next;
    op_q       <= op_q_next;
    addr_q     <= addr_q_next;
    len_q      <= len_q_next;
    port_q     <= port_q_next;
    rsp        <= rsp_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("route count above table size");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state != ipv4_lpm_pkg::ST_IDLE))
    else $error("request transfer did not start a sequence");

  a_write_in_finish: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ipv4_lpm_pkg::ST_FINISH))
    else $error("table write outside finish step");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> ((state == ipv4_lpm_pkg::ST_SCAN) && (idx < count)))
    else $error("table read beyond stored routes");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == ipv4_lpm_pkg::ST_DONE))
    else $error("result loaded outside done step");

endmodule
